// ===== hw/rtl/fam_pkg.sv =====
`default_nettype none

package fam_pkg;

   // operation codes carried on req_func
   localparam logic [1:0] FUNC_REDUCE = 2'd0;
   localparam logic [1:0] FUNC_MUL    = 2'd1;
   localparam logic [1:0] FUNC_ADD    = 2'd2;

   // divider status toward its user
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/fam_div.sv =====
`default_nettype none

// Truncating signed divide, one quotient bit per cycle (restoring).
// Quotient sign is the xor of operand signs, remainder takes the dividend sign.
module fam_div #(
   parameter int WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] dividend,
   input  wire logic [WIDTH-1:0] divisor,
   output fam_pkg::div_status_type status,
   output logic      [WIDTH-1:0] quo,
   output logic      [WIDTH-1:0] rem
);
   import fam_pkg::*;

   localparam int CW = $clog2(WIDTH + 1);

   logic [CW-1:0]    cnt_ff;
   logic             done_ff;
   logic             neg_q_ff;
   logic             neg_r_ff;
   logic [WIDTH-1:0] q_ff;
   logic [WIDTH-1:0] r_ff;
   logic [WIDTH-1:0] b_ff;
   logic [WIDTH-1:0] mag_a;
   logic [WIDTH-1:0] mag_b;
   logic [WIDTH:0]   rem_sh;
   logic [WIDTH:0]   diff;

   // operand magnitudes
   assign mag_a = dividend[WIDTH-1] ? (~dividend + 1'b1) : dividend;
   assign mag_b = divisor[WIDTH-1] ? (~divisor + 1'b1) : divisor;

   // one restoring step
   assign rem_sh = {r_ff, q_ff[WIDTH-1]};
   assign diff   = rem_sh - {1'b0, b_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == CW'(1));
         if (start && cnt_ff == '0) begin
            cnt_ff <= CW'(WIDTH);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && cnt_ff == '0) begin
         neg_q_ff <= dividend[WIDTH-1] ^ divisor[WIDTH-1];
         neg_r_ff <= dividend[WIDTH-1];
         q_ff     <= mag_a;
         r_ff     <= '0;
         b_ff     <= mag_b;
      end else if (cnt_ff != '0) begin
         if (!diff[WIDTH]) begin
            r_ff <= diff[WIDTH-1:0];
            q_ff <= {q_ff[WIDTH-2:0], 1'b1};
         end else begin
            r_ff <= rem_sh[WIDTH-1:0];
            q_ff <= {q_ff[WIDTH-2:0], 1'b0};
         end
      end
   end

   // sign fix-up, valid with done and held until the next start
   assign quo = neg_q_ff ? (~q_ff + 1'b1) : q_ff;
   assign rem = neg_r_ff ? (~r_ff + 1'b1) : r_ff;

   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/fam_queue.sv =====
`default_nettype none

// Small register FIFO between front and back.
module fam_queue #(
   parameter int DW    = 64,
   parameter int DEPTH = 2
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   output logic               push_ready,
   input  wire logic [DW-1:0] push_data,
   output logic               pop_valid,
   input  wire logic          pop_ready,
   output logic      [DW-1:0] pop_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_push;
   logic          do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/fam_front.sv =====
`default_nettype none

// Front: accepts a request, forms the raw numerator and denominator (for
// multiply/add with a shift-add multiplier, one bit per cycle, stopping early
// when the multiplier runs out of ones), then pushes {num, den} to the queue.
module fam_front #(
   parameter int WIDTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_func,
   input  wire logic signed [31:0]   req_a_num,
   input  wire logic signed [31:0]   req_a_den,
   input  wire logic signed [31:0]   req_b_num,
   input  wire logic signed [31:0]   req_b_den,
   output logic                      push_valid,
   input  wire logic                 push_ready,
   output logic      [2*WIDTH-1:0]   push_data
);
   import fam_pkg::*;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_MUL  = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type  state_ff;
   front_state_type  state_in;
   logic [1:0]       op_ff;
   logic [1:0]       stage_ff;
   logic [WIDTH-1:0] an_ff;
   logic [WIDTH-1:0] bn_ff;
   logic [WIDTH-1:0] ad_ff;
   logic [WIDTH-1:0] bd_ff;
   logic [WIDTH-1:0] mcand_ff;
   logic [WIDTH-1:0] mplier_ff;
   logic [WIDTH-1:0] acc_ff;
   logic [WIDTH-1:0] n_ff;
   logic [WIDTH-1:0] d_ff;
   logic             accept;
   logic             prod_done;

   assign req_stall  = (state_ff != F_IDLE);
   assign accept     = req_valid && (state_ff == F_IDLE);
   assign prod_done  = (mplier_ff == '0);
   assign push_valid = (state_ff == F_PUSH);
   assign push_data  = {n_ff, d_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               state_in = (req_func == FUNC_MUL || req_func == FUNC_ADD) ? F_MUL : F_PUSH;
            end
         end
         F_MUL: begin
            if (prod_done && (stage_ff == 2'd2 || (stage_ff == 2'd1 && op_ff == FUNC_MUL))) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (push_ready) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath: denominator product first, then the numerator terms
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_func;
         an_ff    <= WIDTH'(req_a_num);
         ad_ff    <= WIDTH'(req_a_den);
         bn_ff    <= WIDTH'(req_b_num);
         stage_ff <= 2'd0;
         acc_ff   <= '0;
         mcand_ff <= WIDTH'(req_a_den);
         mplier_ff <= WIDTH'(req_b_den);
         case (req_func) inside
            FUNC_MUL, FUNC_ADD: begin
            end
            default: begin
               n_ff <= WIDTH'(req_a_num);
               d_ff <= WIDTH'(req_a_den);
            end
         endcase
      end else if (state_ff == F_MUL) begin
         if (!prod_done) begin
            if (mplier_ff[0]) acc_ff <= acc_ff + mcand_ff;
            mcand_ff  <= mcand_ff << 1;
            mplier_ff <= mplier_ff >> 1;
         end else begin
            case (stage_ff)
               2'd0: begin
                  d_ff      <= acc_ff;
                  acc_ff    <= '0;
                  mcand_ff  <= an_ff;
                  mplier_ff <= (op_ff == FUNC_MUL) ? bn_ff : bd_ff;
                  stage_ff  <= 2'd1;
               end
               2'd1: begin
                  n_ff      <= acc_ff;
                  acc_ff    <= '0;
                  mcand_ff  <= bn_ff;
                  mplier_ff <= ad_ff;
                  stage_ff  <= 2'd2;
               end
               default: begin
                  n_ff <= n_ff + acc_ff;
               end
            endcase
         end
      end
   end

   // b_den, needed for the first cross term
   always_ff @(posedge clock) begin
      if (accept) bd_ff <= WIDTH'(req_b_den);
   end

endmodule

`default_nettype wire

// ===== hw/rtl/fam_back.sv =====
`default_nettype none

// Back: Euclid GCD by repeated truncating remainders, then num/g and den/g,
// all on one shared serial divider; 0/0 if g is zero. Result held in output regs.
module fam_back #(
   parameter int WIDTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 pop_valid,
   output logic                      pop_ready,
   input  wire logic [2*WIDTH-1:0]   pop_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [31:0]        rsp_res_num,
   output logic signed [31:0]        rsp_res_den,
   output logic                      rsp_zero_gcd
);
   import fam_pkg::*;

   typedef enum logic [5:0] {
      B_IDLE  = 6'b000001,
      B_GCD   = 6'b000010,
      B_GCDW  = 6'b000100,
      B_DIVNW = 6'b001000,
      B_DIVDW = 6'b010000,
      B_OUT   = 6'b100000
   } back_state_type;

   back_state_type   state_ff;
   back_state_type   state_in;
   logic [WIDTH-1:0] n_ff;
   logic [WIDTH-1:0] d_ff;
   logic [WIDTH-1:0] u_ff;
   logic [WIDTH-1:0] v_ff;
   logic [WIDTH-1:0] qn_ff;
   logic signed [31:0] res_num_ff;
   logic signed [31:0] res_den_ff;
   logic             zero_ff;
   logic             gcd_zero;
   logic             div_start;
   logic [WIDTH-1:0] div_a;
   logic [WIDTH-1:0] div_b;
   logic [WIDTH-1:0] div_q;
   logic [WIDTH-1:0] div_r;
   div_status_type   div_st;

   fam_div #(.WIDTH(WIDTH)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .status   (div_st),
      .quo      (div_q),
      .rem      (div_r)
   );

   assign pop_ready = (state_ff == B_IDLE);
   assign gcd_zero  = (u_ff == '0);

   // divider operand select; u_ff holds g once v reaches zero
   always_comb begin
      div_a = u_ff;
      div_b = v_ff;
      if (state_ff == B_GCD && v_ff == '0) begin
         div_a = n_ff;
         div_b = u_ff;
      end else if (state_ff == B_DIVNW) begin
         div_a = d_ff;
         div_b = u_ff;
      end
   end

   assign div_start = (state_ff == B_GCD && !(v_ff == '0 && gcd_zero)) ||
                      (state_ff == B_DIVNW && div_st.done);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:  if (pop_valid) state_in = B_GCD;
         B_GCD: begin
            if (v_ff != '0)   state_in = B_GCDW;
            else if (gcd_zero) state_in = B_OUT;
            else              state_in = B_DIVNW;
         end
         B_GCDW:  if (div_st.done) state_in = B_GCD;
         B_DIVNW: if (div_st.done) state_in = B_DIVDW;
         B_DIVDW: if (div_st.done) state_in = B_OUT;
         B_OUT:   if (!rsp_stall) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == B_IDLE && pop_valid) begin
         n_ff <= pop_data[2*WIDTH-1:WIDTH];
         d_ff <= pop_data[WIDTH-1:0];
         u_ff <= pop_data[2*WIDTH-1:WIDTH];
         v_ff <= pop_data[WIDTH-1:0];
      end
      if (state_ff == B_GCD && v_ff == '0 && gcd_zero) begin
         res_num_ff <= '0;
         res_den_ff <= '0;
         zero_ff    <= 1'b1;
      end
      if (state_ff == B_GCDW && div_st.done) begin
         u_ff <= v_ff;
         v_ff <= div_r;
      end
      if (state_ff == B_DIVNW && div_st.done) begin
         qn_ff <= div_q;
      end
      if (state_ff == B_DIVDW && div_st.done) begin
         res_num_ff <= 32'(signed'(qn_ff));
         res_den_ff <= 32'(signed'(div_q));
         zero_ff    <= 1'b0;
      end
   end

   assign rsp_valid    = (state_ff == B_OUT);
   assign rsp_res_num  = res_num_ff;
   assign rsp_res_den  = res_den_ff;
   assign rsp_zero_gcd = zero_ff;

   // checks
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_st.busy) else $error("divider started while busy");

   a_done_waiting: assert property (@(posedge clock) disable iff (reset)
      div_st.done |-> (state_ff == B_GCDW || state_ff == B_DIVNW || state_ff == B_DIVDW))
      else $error("divider result with nobody waiting");

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_gcd) |-> (rsp_res_num == '0 && rsp_res_den == '0))
      else $error("zero gcd flag with nonzero result");

endmodule

`default_nettype wire

// ===== hw/rtl/fraction_add_mul_reduce.sv =====
`default_nettype none

// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_stall  | func, a_num, a_den, b_num, b_den
// rsp     | out       | rsp_valid/rsp_stall  | res_num, res_den, zero_gcd
//
// Front: reduce skips the multiplier and goes straight to the queue; multiply
// forms 2 products and add 3, each on the serial shift-add multiplier.
// Back: one serial divide per Euclid remainder step, then, unless g is zero,
// two final divides for num/g and den/g on the same shared divider.
// Reset is synchronous; no storage needs clearing. A stalled rsp holds the
// back, the queue then fills and the front stalls req.
module fraction_add_mul_reduce #(
   parameter int WIDTH       = 32,
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_func,
   input  wire logic signed [31:0] req_a_num,
   input  wire logic signed [31:0] req_a_den,
   input  wire logic signed [31:0] req_b_num,
   input  wire logic signed [31:0] req_b_den,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_res_num,
   output logic signed [31:0]      rsp_res_den,
   output logic                    rsp_zero_gcd
);

   logic               push_valid;
   logic               push_ready;
   logic [2*WIDTH-1:0] push_data;
   logic               pop_valid;
   logic               pop_ready;
   logic [2*WIDTH-1:0] pop_data;

   fam_front #(.WIDTH(WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_func   (req_func),
      .req_a_num  (req_a_num),
      .req_a_den  (req_a_den),
      .req_b_num  (req_b_num),
      .req_b_den  (req_b_den),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   fam_queue #(.DW(2 * WIDTH), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   fam_back #(.WIDTH(WIDTH)) u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_data     (pop_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_res_num  (rsp_res_num),
      .rsp_res_den  (rsp_res_den),
      .rsp_zero_gcd (rsp_zero_gcd)
   );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import fam_pkg::*;

   localparam int W = 32;
   localparam int NUM_RANDOM = 1830;
   localparam int CALM_TAIL = 150;
   localparam longint CYCLE_LIMIT = 20000000;

   typedef logic signed [W-1:0] word_type;

   typedef struct {
      logic [1:0] func;
      word_type   a_num, a_den, b_num, b_den;
   } request_type;

   typedef struct {
      word_type res_num, res_den;
      logic     zero_gcd;
   } fraction_type;

   typedef struct {
      request_type  req;
      bit           typed;
      fraction_type res;
   } vector_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_func = FUNC_REDUCE;
   word_type   req_a_num = '0, req_a_den = '0, req_b_num = '0, req_b_den = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   word_type   rsp_res_num, rsp_res_den;
   logic       rsp_zero_gcd;

   fraction_type pending_results[$];
   int           error_count = 0;
   longint       cycle_count = 0;
   bit           stim_done = 1'b0;
   bit           calm = 1'b0;

   fraction_add_mul_reduce uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_a_num(req_a_num), .req_a_den(req_a_den),
      .req_b_num(req_b_num), .req_b_den(req_b_den),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_res_num(rsp_res_num), .rsp_res_den(rsp_res_den),
      .rsp_zero_gcd(rsp_zero_gcd)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // truncating signed divide/remainder, most negative / -1 wraps
   function automatic word_type trunc_div(word_type x, word_type y);
      logic [W-1:0] mx, my, q;
      mx = x[W-1] ? -x : x;
      my = y[W-1] ? -y : y;
      q = mx / my;
      return (x[W-1] != y[W-1]) ? -q : q;
   endfunction

   function automatic word_type trunc_rem(word_type x, word_type y);
      logic [W-1:0] mx, my, r;
      mx = x[W-1] ? -x : x;
      my = y[W-1] ? -y : y;
      r = mx % my;
      return x[W-1] ? -r : r;
   endfunction

   function automatic fraction_type reduced_fraction(request_type r);
      word_type n, d, u, v, t;
      fraction_type f;
      case (r.func)
         FUNC_MUL: begin
            n = r.a_num * r.b_num;
            d = r.a_den * r.b_den;
         end
         FUNC_ADD: begin
            n = r.a_num * r.b_den + r.b_num * r.a_den;
            d = r.a_den * r.b_den;
         end
         default: begin
            n = r.a_num;
            d = r.a_den;
         end
      endcase
      u = n;
      v = d;
      while (v != 0) begin
         t = trunc_rem(u, v);
         u = v;
         v = t;
      end
      if (u == 0) begin
         f.res_num = '0;
         f.res_den = '0;
         f.zero_gcd = 1'b1;
      end else begin
         f.res_num = trunc_div(n, u);
         f.res_den = trunc_div(d, u);
         f.zero_gcd = 1'b0;
      end
      return f;
   endfunction

   task automatic report_mismatch(string what, word_type got, word_type want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   function automatic word_type rand_word();
      case ($urandom_range(0, 5))
         0: return word_type'($urandom_range(0, 20)) - 10;
         1: return word_type'($urandom_range(0, 2000)) - 1000;
         2: return {1'b1, 31'($urandom_range(0, 3))};
         3: return {1'b0, {28{1'b1}}, 3'($urandom)};
         4: return word_type'($urandom_range(0, 60000)) - 30000;
         default: return word_type'($urandom);
      endcase
   endfunction

   // send one request; the expected result is queued as it transfers
   task automatic send_request(request_type r, bit typed, fraction_type want);
      fraction_type f;
      f = typed ? want : reduced_fraction(r);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= r.func;
      req_a_num <= r.a_num;
      req_a_den <= r.a_den;
      req_b_num <= r.b_num;
      req_b_den <= r.b_den;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(f);
   endtask

   // result side: random stall bursts and field checks
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $display("unexpected result %0d/%0d", rsp_res_num, rsp_res_den);
               error_count++;
            end else begin
               fraction_type e;
               e = pending_results.pop_front();
               if (rsp_res_num !== e.res_num)
                  report_mismatch("res_num", rsp_res_num, e.res_num);
               if (rsp_res_den !== e.res_den)
                  report_mismatch("res_den", rsp_res_den, e.res_den);
               if (rsp_zero_gcd !== e.zero_gcd)
                  report_mismatch("zero_gcd", word_type'(rsp_zero_gcd),
                                  word_type'(e.zero_gcd));
            end
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (calm) rsp_stall <= 1'b0;
         else if ($urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL fraction_add_mul_reduce");
         $finish;
      end
   end

   localparam word_type MINV = {1'b1, {(W-1){1'b0}}};
   localparam word_type MAXV = {1'b0, {(W-1){1'b1}}};
   localparam fraction_type ZERO_RES = '{res_num: '0, res_den: '0, zero_gcd: 1'b1};

   vector_type directed[] = '{
      '{'{FUNC_REDUCE, 0, 0, 5, 7}, 1, ZERO_RES},
      '{'{FUNC_REDUCE, 6, 4, 0, 0}, 1, '{3, 2, 1'b0}},
      '{'{FUNC_REDUCE, 5, 0, 0, 0}, 1, '{1, 0, 1'b0}},
      '{'{FUNC_REDUCE, 0, 9, 0, 0}, 1, '{0, 1, 1'b0}},
      '{'{FUNC_REDUCE, -6, 4, 0, 0}, 0, ZERO_RES},
      '{'{FUNC_REDUCE, 6, -4, 0, 0}, 0, ZERO_RES},
      '{'{FUNC_REDUCE, MINV, -1, 0, 0}, 0, ZERO_RES},
      '{'{FUNC_REDUCE, MINV, MINV, 0, 0}, 1, '{1, 1, 1'b0}},
      '{'{FUNC_REDUCE, MAXV, MAXV, 0, 0}, 1, '{1, 1, 1'b0}},
      '{'{FUNC_REDUCE, MAXV, MINV, 0, 0}, 0, ZERO_RES},
      '{'{FUNC_REDUCE, -1, -1, 0, 0}, 0, ZERO_RES},
      '{'{2'd3, 10, 15, 1, 1}, 0, ZERO_RES},
      '{'{2'd3, 0, 0, -1, -1}, 1, ZERO_RES},
      '{'{FUNC_MUL, 2, 3, 3, 4}, 0, ZERO_RES},
      '{'{FUNC_MUL, 0, 5, 7, 0}, 1, ZERO_RES},
      '{'{FUNC_MUL, MINV, MAXV, -1, MINV}, 0, ZERO_RES},
      '{'{FUNC_MUL, MAXV, MAXV, MAXV, MAXV}, 0, ZERO_RES},
      '{'{FUNC_MUL, -1, -1, -1, -1}, 0, ZERO_RES},
      '{'{FUNC_ADD, 1, 2, 1, 3}, 0, ZERO_RES},
      '{'{FUNC_ADD, 1, 2, -1, 2}, 0, ZERO_RES},
      '{'{FUNC_ADD, 0, 0, 0, 0}, 1, ZERO_RES},
      '{'{FUNC_ADD, MINV, 1, MINV, 1}, 0, ZERO_RES},
      '{'{FUNC_ADD, MAXV, MINV, MINV, MAXV}, 0, ZERO_RES},
      '{'{FUNC_ADD, -1, -1, -1, -1}, 0, ZERO_RES}
   };

   initial begin
      request_type r;
      int wait_cycles;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed[i])
         send_request(directed[i].req, directed[i].typed, directed[i].res);

      // random part, small operands half the time, else near the extremes or full range; calm tail
      for (int i = 0; i < NUM_RANDOM; i++) begin
         if (i == NUM_RANDOM - CALM_TAIL) calm = 1'b1;
         r.func  = 2'($urandom_range(0, 3));
         r.a_num = rand_word();
         r.a_den = rand_word();
         r.b_num = rand_word();
         r.b_den = rand_word();
         if ($urandom_range(0, 15) == 0) begin
            r.a_num = 0;
            r.a_den = 0;
         end
         send_request(r, 1'b0, ZERO_RES);
      end
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (pending_results.size() != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (400) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("PASS fraction_add_mul_reduce");
      end else begin
         if (pending_results.size() != 0)
            $display("%0d results never arrived", pending_results.size());
         $display("FAIL fraction_add_mul_reduce");
      end
      $finish;
   end
endmodule

`default_nettype wire

// ===== fraction_add_mul_reduce.f =====
hw/rtl/fam_pkg.sv
hw/rtl/fam_div.sv
hw/rtl/fam_queue.sv
hw/rtl/fam_front.sv
hw/rtl/fam_back.sv
hw/rtl/fraction_add_mul_reduce.sv
test/testbench.sv
